/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define SMF_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition holds in the cycle after an antecedent
`define SMF_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/smf_pkg.sv */
// ----------------------------------------------------------------------------
// Median filter package
// Fixed widths and the request passed from the control to the selector.
// ----------------------------------------------------------------------------
package smf_pkg;

  // Width of the radius register
  localparam int RADIUS_BITS = 3;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 3'd1;

  // Ages and effective radius fit in four bits for any supported radius
  localparam int AGE_BITS = 4;

  // Selection request: which age to read and whether it takes the median
  typedef struct packed {
    logic [AGE_BITS-1:0] age;
    logic                use_median;
  } sel_req_t;

endpackage

/* rtl/smf_cell.sv */
// ----------------------------------------------------------------------------
// Median filter window cell
// Holds one sample of the delay line and its order bits against all younger
// samples; takes both from its neighbour on every shift.
// ----------------------------------------------------------------------------
module smf_cell
  import smf_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int LINK_BITS   = 14
) (
  input  logic                          clk,
  input  logic                          shift_en,
  input  logic signed [SAMPLE_BITS-1:0] new_sample,
  input  logic signed [SAMPLE_BITS-1:0] prev_sample,
  input  logic        [LINK_BITS-1:0]   prev_links,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic        [LINK_BITS-1:0]   links_o
);

  logic signed [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic        [LINK_BITS-1:0]   links_r, links_nxt;

  // Take the neighbour's sample; age its order bits and add the newest pair.
  // A bit is set when the younger sample sorts first (ties go to the younger).
  always_comb begin
    sample_nxt = prev_sample;
    links_nxt  = {prev_links[LINK_BITS-2:0], (new_sample <= prev_sample)};
  end

  // Hold unless a request shifts the line
  always_ff @(posedge clk) begin
    if (shift_en) begin
      sample_r <= sample_nxt;
      links_r  <= links_nxt;
    end
  end

  assign sample_o = sample_r;
  assign links_o  = links_r;

endmodule

/* rtl/smf_select.sv */
// ----------------------------------------------------------------------------
// Median filter selector
// Ranks the samples inside the window from the stored order bits and picks
// either the median or the raw sample of a given age.
// ----------------------------------------------------------------------------
module smf_select
  import smf_pkg::*;
#(
  parameter int MAX_RADIUS  = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic signed [SAMPLE_BITS-1:0] win_sample [2*MAX_RADIUS+1],
  input  logic        [2*MAX_RADIUS-1:0] win_links [2*MAX_RADIUS+1],
  input  logic        [AGE_BITS-1:0]    radius,
  input  sel_req_t                      req,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);

  localparam int DEPTH    = 2 * MAX_RADIUS + 1;
  localparam int LEN_BITS = AGE_BITS + 1;

  logic [LEN_BITS-1:0]           win_len;
  logic [DEPTH-1:0]              in_win;
  logic [DEPTH-1:0]              pred     [DEPTH];
  logic [DEPTH-1:0]              rank_hit;
  logic signed [SAMPLE_BITS-1:0] median;
  logic signed [SAMPLE_BITS-1:0] raw;

  assign win_len = {radius, 1'b1};

  // Mark the ages inside the current window
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      in_win[i] = (LEN_BITS'(i) < win_len);
    end
  end

  // Collect, for every age, the window samples that sort before it
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      for (int j = 0; j < DEPTH; j++) begin
        if (j < i) begin
          pred[i][j] = win_links[i][j] & in_win[j];
        end else if (j > i) begin
          pred[i][j] = ~win_links[j][i] & in_win[j];
        end else begin
          pred[i][j] = 1'b0;
        end
      end
    end
  end

  // Find the window sample with exactly radius samples before it
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      rank_hit[i] = in_win[i] && ($countones(pred[i]) == int'(radius));
    end
  end

  // Drive the median and the raw sample through one-hot selection
  always_comb begin
    median = '0;
    raw    = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (rank_hit[i]) begin
        median = median | win_sample[i];
      end
      if (int'(req.age) == i) begin
        raw = raw | win_sample[i];
      end
    end
  end

  assign sample_o = req.use_median ? median : raw;

endmodule

/* rtl/sliding_median_filter_unit.sv */
// ----------------------------------------------------------------------------
// Sliding median filter unit - a registered job stage, then the output register.
// One sample per cycle unless stalled; a last one holds input while it flushes.
// Reset: radius 1, sample count and all pending results cleared at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_median_filter_unit
  import smf_pkg::*;
#(
  parameter int MAX_RADIUS  = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [RADIUS_BITS-1:0]        cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                          in_end_of_signal,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_last_out
);

  localparam int DEPTH      = 2 * MAX_RADIUS + 1;
  localparam int LINK_BITS  = 2 * MAX_RADIUS;
  localparam int COUNT_BITS = $clog2(DEPTH + 1);
  localparam int CMP_BITS   = COUNT_BITS + 1;

  // Configuration and control state
  logic [RADIUS_BITS-1:0] radius_r, radius_nxt;
  logic [COUNT_BITS-1:0]  seen_r, seen_nxt;
  logic                   p_valid_r, p_valid_nxt;
  logic [AGE_BITS-1:0]    p_age_r, p_age_nxt;
  logic                   p_last_r, p_last_nxt;
  logic                   p_med_r, p_med_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [AGE_BITS-1:0]    r_eff;
  logic [CMP_BITS-1:0]    n_ext;
  logic [CMP_BITS-1:0]    r_ext;
  logic                   out_free;
  logic                   move;
  logic                   p_done;
  logic                   acc;
  logic                   short_run;
  logic                   job_new;

  logic signed [SAMPLE_BITS-1:0] win_sample [DEPTH];
  logic        [LINK_BITS-1:0]   win_links  [DEPTH];
  sel_req_t                      sel_req;
  logic signed [SAMPLE_BITS-1:0] sel_sample;

  // Clamp the radius to the window the line can hold
  assign r_eff = (AGE_BITS'(radius_r) > AGE_BITS'(MAX_RADIUS)) ?
                 AGE_BITS'(MAX_RADIUS) : AGE_BITS'(radius_r);

  assign n_ext = CMP_BITS'(seen_r);
  assign r_ext = CMP_BITS'(r_eff);

  // Handshake: advance the job into the output register when it is free
  assign out_free  = !out_valid_r || !out_stall;
  assign move      = p_valid_r && out_free;
  assign p_done    = move && (!p_last_r || (p_age_r == '0));
  assign in_stall  = p_valid_r && !p_done;
  assign acc       = in_valid && !in_stall;
  assign short_run = n_ext < r_ext;
  assign job_new   = acc && (in_end_of_signal || !short_run);

  // Window delay line: cell 0 takes the new sample directly
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      smf_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LINK_BITS   (LINK_BITS)
      ) u_cell (
        .clk         (clk),
        .shift_en    (acc),
        .new_sample  (in_sample_in),
        .prev_sample (in_sample_in),
        .prev_links  ('0),
        .sample_o    (win_sample[g]),
        .links_o     (win_links[g])
      );
    end else begin : g_body
      smf_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LINK_BITS   (LINK_BITS)
      ) u_cell (
        .clk         (clk),
        .shift_en    (acc),
        .new_sample  (in_sample_in),
        .prev_sample (win_sample[g-1]),
        .prev_links  (win_links[g-1]),
        .sample_o    (win_sample[g]),
        .links_o     (win_links[g])
      );
    end
  end

  // Pick the result for the job's current age
  always_comb begin
    sel_req.age        = p_age_r;
    sel_req.use_median = p_med_r && (p_age_r == r_eff);
  end

  smf_select #(
    .MAX_RADIUS  (MAX_RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_select (
    .win_sample (win_sample),
    .win_links  (win_links),
    .radius     (r_eff),
    .req        (sel_req),
    .sample_o   (sel_sample)
  );

  // Next-state logic for radius, count, job and output register
  always_comb begin
    radius_nxt     = radius_r;
    seen_nxt       = seen_r;
    p_valid_nxt    = p_valid_r;
    p_age_nxt      = p_age_r;
    p_last_nxt     = p_last_r;
    p_med_nxt      = p_med_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;

    if (cfg_wr_en) begin
      radius_nxt = cfg_wr_data;
    end

    // Count samples of the current signal; drop the count after a last one
    if (acc) begin
      if (in_end_of_signal) begin
        seen_nxt = '0;
      end else if (seen_r < COUNT_BITS'(DEPTH)) begin
        seen_nxt = seen_r + 1'b1;
      end
    end

    // Step the job: retire it, count a flush down, or load a new request
    if (p_done) begin
      p_valid_nxt = 1'b0;
    end else if (move) begin
      p_age_nxt = p_age_r - 1'b1;
    end
    if (job_new) begin
      p_valid_nxt = 1'b1;
      p_last_nxt  = in_end_of_signal;
      p_med_nxt   = n_ext >= (r_ext << 1);
      p_age_nxt   = (in_end_of_signal && short_run) ? AGE_BITS'(seen_r) : r_eff;
    end

    // Hold the output until taken, then refill from the job
    if (move) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = sel_sample;
      out_last_nxt   = p_last_r && (p_age_r == '0);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= RADIUS_RESET;
      seen_r      <= '0;
      p_valid_r   <= 1'b0;
      p_age_r     <= '0;
      p_last_r    <= 1'b0;
      p_med_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      radius_r    <= radius_nxt;
      seen_r      <= seen_nxt;
      p_valid_r   <= p_valid_nxt;
      p_age_r     <= p_age_nxt;
      p_last_r    <= p_last_nxt;
      p_med_r     <= p_med_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
    out_sample_r <= out_sample_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_last_out   = out_last_r;

  // Checks on the job control
  `SMF_CHECK(a_stall_only_busy, !p_valid_r |-> !in_stall, "input stalled with no job pending")
  `SMF_CHECK(a_age_in_window, p_valid_r |-> (p_age_r <= r_eff), "job age beyond radius")
  `SMF_CHECK_NEXT(a_last_clears_count, acc && in_end_of_signal, seen_r == '0, "count kept")

endmodule

/* dv/tb_sliding_median_filter_unit.sv */
// ----------------------------------------------------------------------------
// Sliding median filter unit testbench
// Drives whole signals through the filter at a range of radii and runs a
// predictor of the filter alongside it. A scoreboard compares every result
// with the oldest expected one. Directed signals cover the value extremes,
// pass-through, short signals and flushes. Random signals then run under
// sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_sliding_median_filter_unit;
  import smf_pkg::*;

  localparam int MAX_RADIUS     = 7;
  localparam int SAMPLE_BITS    = 16;
  localparam int WIN_DEPTH      = 2 * MAX_RADIUS + 1;
  localparam int LATENCY        = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 300;
  localparam int PHASE_ITEMS    = 30;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    last;
  } filt_result_t;

  // Predictor of the filter plus the queue of results still to arrive
  class median_scoreboard;
    sample_t      window [WIN_DEPTH];
    int unsigned  seen;
    int unsigned  radius_val;
    filt_result_t expected_q [$];
    int           errors;
    int           n_results;

    function new();
      radius_val = RADIUS_RESET;
      seen       = 0;
      errors     = 0;
      n_results  = 0;
      foreach (window[i]) window[i] = '0;
    endfunction

    function void set_radius(int unsigned r);
      radius_val = r;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Median of the 2r+1 newest samples
    function sample_t window_median(int unsigned r);
      sample_t buf_s [WIN_DEPTH];
      sample_t v;
      int      a;
      int      b;
      for (a = 0; a < 2 * r + 1; a++) buf_s[a] = window[a];
      for (a = 1; a < 2 * r + 1; a++) begin
        v = buf_s[a];
        b = a;
        while (b > 0 && buf_s[b-1] > v) begin
          buf_s[b] = buf_s[b-1];
          b--;
        end
        buf_s[b] = v;
      end
      return buf_s[r];
    endfunction

    // Shift in an accepted request and queue the results it releases
    function void note_input(sample_t s, logic last);
      int unsigned  r;
      int unsigned  n;
      int           first_age;
      int           a;
      filt_result_t res;
      r = (radius_val > MAX_RADIUS) ? MAX_RADIUS : radius_val;
      n = seen;
      for (a = WIN_DEPTH - 1; a > 0; a--) window[a] = window[a-1];
      window[0] = s;
      if (last) begin
        first_age = (n < r) ? n : r;
      end else begin
        if (n < r) begin
          seen = n + 1;
          return;
        end
        first_age = r;
      end
      for (a = first_age; a >= 0; a--) begin
        if (a == r && n >= 2 * r) res.sample = window_median(r);
        else res.sample = window[a];
        res.last = last && (a == 0);
        expected_q.insert(expected_q.size(), res);
        if (!last) break;
      end
      if (last) seen = 0;
      else if (n < WIN_DEPTH) seen = n + 1;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Compare a result with the oldest expectation, field by field
    task check_result(sample_t s, logic last);
      filt_result_t exp_r;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result sample %0d last %0b", s, last));
      end else begin
        exp_r = expected_q.pop_front();
        n_results++;
        if (s !== exp_r.sample)
          report_mismatch($sformatf("result %0d: sample %0d, expected %0d",
                                    n_results, s, exp_r.sample));
        if (last !== exp_r.last)
          report_mismatch($sformatf("result %0d: last %0b, expected %0b",
                                    n_results, last, exp_r.last));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [RADIUS_BITS-1:0] cfg_wr_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  sample_t                in_sample_in = '0;
  logic                   in_end_of_signal = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  sample_t                out_sample_out;
  logic                   out_last_out;

  median_scoreboard sb;
  int   idle_pct = 0;
  int   stall_pct = 0;
  logic hold_active = 1'b0;
  int   n_requests = 0;
  int   n_signals = 0;
  int   idle_cycles = 0;
  logic [7:0] radii_used = '0;
  event hold_go;

  sliding_median_filter_unit #(
    .MAX_RADIUS  (MAX_RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_in     (in_sample_in),
    .in_end_of_signal (in_end_of_signal),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_out   (out_sample_out),
    .out_last_out     (out_last_out)
  );

  always #5 clk = ~clk;

  // Hold off the receiver for a long stretch when asked
  always begin
    @(hold_go);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  // Receiver stall, changed on the falling edge
  always @(negedge clk) begin
    out_stall = hold_active || ($urandom_range(99) < stall_pct);
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_sample_out, out_last_out);
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("sliding_median_filter_unit verification failed");
        $finish;
      end
    end
  end

  // Offer one request, with a random gap first, and wait for it to be taken
  task send_request(input sample_t s, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_sample_in     = s;
    in_end_of_signal = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(s, last);
    n_requests++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected result has come out
  task drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task write_radius(input int unsigned r);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = r[RADIUS_BITS-1:0];
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_radius(r);
    radii_used[r] = 1'b1;
  endtask

  // Extremes, runs of near values for ties, and fully random words
  function sample_t rand_sample();
    case ($urandom_range(9))
      0:       return sample_t'(16'h7FFF);
      1:       return sample_t'(16'h8000);
      2, 3, 4: return sample_t'($urandom_range(16)) - sample_t'(8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task send_signal(input int len);
    int i;
    for (i = 0; i < len; i++) send_request(rand_sample(), i == len - 1);
    n_signals++;
  endtask

  initial begin
    int          phase;
    int          phase_items;
    int          len;
    int unsigned r;
    sb = new();

    // Hold reset, then release it
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    radii_used[RADIUS_RESET] = 1'b1;

    // Reset radius: extremes through a three-wide window
    send_request(sample_t'(16'h7FFF), 1'b0);
    send_request(sample_t'(16'h8000), 1'b0);
    send_request(sample_t'(0), 1'b0);
    send_request(sample_t'(-1), 1'b0);
    send_request(sample_t'(1), 1'b1);
    // Single-sample signal passes through raw
    send_request(sample_t'(5), 1'b1);
    n_signals += 2;
    drain();

    // Zero radius: straight pass-through
    write_radius(0);
    send_request(sample_t'(16'h8000), 1'b0);
    send_request(sample_t'(16'h7FFF), 1'b0);
    send_request(sample_t'(-3), 1'b1);
    n_signals++;
    drain();

    // Signal exactly one window long
    write_radius(3);
    send_request(sample_t'(100), 1'b0);
    send_request(sample_t'(16'h8000), 1'b0);
    send_request(sample_t'(16'h7FFF), 1'b0);
    send_request(sample_t'(-5), 1'b0);
    send_request(sample_t'(-5), 1'b0);
    send_request(sample_t'(0), 1'b0);
    send_request(sample_t'(1), 1'b1);
    n_signals++;
    drain();

    // Largest radius with a short signal: flush before enough samples
    write_radius(MAX_RADIUS);
    send_request(sample_t'(16'h7FFF), 1'b0);
    send_request(sample_t'(16'h8000), 1'b0);
    send_request(sample_t'(7), 1'b0);
    send_request(sample_t'(-7), 1'b1);
    n_signals++;
    drain();

    // Random signals, one radius per phase, cycling the idling mode
    phase = 0;
    while (n_requests < RANDOM_ITEMS - 20) begin
      if (phase == 0) r = MAX_RADIUS;
      else if (phase == 1) r = 0;
      else r = $urandom_range(MAX_RADIUS);
      write_radius(r);
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      // Fill the block while the receiver holds off
      if (phase == 4) -> hold_go;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(3) == 0) len = $urandom_range(1, 2 * r + 1);
        else len = $urandom_range(2 * r + 1, 2 * r + 20);
        send_signal(len);
        phase_items += len;
      end
      drain();
      phase++;
    end
    idle_pct  = 0;
    stall_pct = 0;
    drain();

    $display("Run covered %0d signals in %0d requests and %0d results, %0d radius values.",
             n_signals, n_requests, sb.n_results, $countones(radii_used));
    $display("Idling modes, a long receiver hold-off, short signals and flushes included.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sliding_median_filter_unit verification clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending());
      $display("sliding_median_filter_unit verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/smf_pkg.sv
rtl/smf_cell.sv
rtl/smf_select.sv
rtl/sliding_median_filter_unit.sv
dv/tb_sliding_median_filter_unit.sv
